@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and codes shared by the block bitmap allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int MAP_BITS  = 8192;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
    localparam int WORD_W    = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int COUNT_W   = 14;
    // Width of a slot count expressed in whole words.
    localparam int LW_W      = COUNT_W - WORD_W;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = COUNT_W'(8192);

    typedef enum logic
    {
        OP_ALLOC,
        OP_FREE
    } bba_op_t;

    typedef enum logic [1:0]
    {
        ST_OK,
        ST_FULL,
        ST_RANGE,
        ST_ALREADY_FREE
    } bba_status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_DONE
    } bba_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;          // capture a request and point at its first word
        logic step;          // advance to the next bitmap word
        logic decide_alloc;  // settle an allocation on the current word
        logic decide_free;   // settle a free on the current word
        logic push;          // move the result into the output register
    } bba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic hit;           // current word has a usable clear bit
        logic last_word;     // current word is the last one below the limit
        logic out_free;      // output register can take a result this cycle
    } bba_stat_t;

endpackage

`default_nettype wire

@@ hdl/bba_req_if.sv @@
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: operation and slot number with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [bba_pkg::COUNT_W-1:0]  slot_number;

    modport source (output valid, output op, output slot_number, input ready);
    modport sink   (input valid, input op, input slot_number, output ready);
endinterface

`default_nettype wire

@@ hdl/bba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: status, granted slot and free count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [bba_pkg::COUNT_W-1:0]  granted_number;
    logic [bba_pkg::COUNT_W-1:0]  free_slots;

    modport source (output valid, output status, output granted_number,
                    output free_slots, input ready);
    modport sink   (input valid, input status, input granted_number,
                    input free_slots, output ready);
endinterface

`default_nettype wire

@@ hdl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller state machine: sequences the word scan, the free check and the
// hand-over of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_op,
    input  wire bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t       cmd,
    output logic                    req_ready
);

    bba_pkg::bba_state_t state_reg;
    bba_pkg::bba_state_t state_next;
    logic                accept;

    assign accept = req_valid && (state_reg == bba_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_op == bba_pkg::OP_FREE) ? bba_pkg::S_FCHK
                                                               : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN:
            begin
                if (stat.hit || stat.last_word)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_FCHK:
            begin
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = accept;
            end
            bba_pkg::S_SCAN:
            begin
                cmd.decide_alloc = stat.hit || stat.last_word;
                cmd.step         = !(stat.hit || stat.last_word);
            end
            bba_pkg::S_FCHK:
            begin
                cmd.decide_free = 1'b1;
            end
            bba_pkg::S_DONE:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory with per-word valid bits, word pointer, first-zero search,
// used-slot counter, block count register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bba_pkg::bba_cmd_t            cmd,
    output bba_pkg::bba_stat_t                stat,
    input  wire logic                         req_op,
    input  wire logic [bba_pkg::COUNT_W-1:0]  req_slot_number,
    input  wire logic                         block_count_we,
    input  wire logic [bba_pkg::COUNT_W-1:0]  block_count_wdata,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        out_status,
    output logic [bba_pkg::COUNT_W-1:0]       out_granted,
    output logic [bba_pkg::COUNT_W-1:0]       out_free_slots
);

    localparam int CW = bba_pkg::COUNT_W;
    localparam int WB = bba_pkg::WORD_BITS;
    localparam int WW = bba_pkg::WORD_W;
    localparam int AW = bba_pkg::ADDR_W;
    localparam int LW = bba_pkg::LW_W;

    // Bitmap storage; a word whose valid bit is clear reads as all free.
    logic [WB-1:0]                   mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0]   vld_reg;
    logic [WB-1:0]                   rdata_reg;
    logic                            rvld_reg;

    logic [CW-1:0]                   block_count_reg;
    logic [CW-1:0]                   used_reg;
    logic [CW-1:0]                   num_reg;
    logic [AW-1:0]                   ptr_reg;
    logic [AW-1:0]                   ptr_next;
    bba_pkg::bba_status_t            res_status_reg;
    logic [CW-1:0]                   res_granted_reg;

    logic                            out_valid_reg;
    logic [1:0]                      out_status_reg;
    logic [CW-1:0]                   out_granted_reg;
    logic [CW-1:0]                   out_free_reg;

    logic [CW-1:0]                   lim;
    logic [LW-1:0]                   lim_word;
    logic [WW-1:0]                   lim_bit;
    logic [LW-1:0]                   nwords;
    logic [LW-1:0]                   ptr_ext;
    logic [WB-1:0]                   low_mask;
    logic [WB-1:0]                   over_mask;
    logic [WB-1:0]                   rword;
    logic [WB-1:0]                   free_vec;
    logic [WW-1:0]                   first_idx;
    logic [CW-1:0]                   req_m1;
    logic [CW-1:0]                   num_m1;
    logic                            num_bad;
    logic                            num_set;
    logic                            we;
    logic [WB-1:0]                   wdata;

    assign lim      = (block_count_reg > CW'(bba_pkg::MAP_BITS)) ? CW'(bba_pkg::MAP_BITS)
                                                                 : block_count_reg;
    assign lim_word = lim[CW-1:WW];
    assign lim_bit  = lim[WW-1:0];
    assign nwords   = lim_word + LW'(|lim_bit);
    assign ptr_ext  = LW'(ptr_reg);

    // Bits at or above the limit count as taken during the scan.
    assign low_mask = (WB'(1) << lim_bit) - WB'(1);

    always_comb
    begin
        priority if (ptr_ext > lim_word)
        begin
            over_mask = '1;
        end
        else if (ptr_ext == lim_word)
        begin
            over_mask = ~low_mask;
        end
        else
        begin
            over_mask = '0;
        end
    end

    assign rword    = rvld_reg ? rdata_reg : '0;
    assign free_vec = ~(rword | over_mask);

    always_comb
    begin
        first_idx = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                first_idx = WW'(i);
            end
        end
    end

    assign stat.hit       = |free_vec;
    assign stat.last_word = (ptr_ext + LW'(1)) >= nwords;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign req_m1  = req_slot_number - CW'(1);
    assign num_m1  = num_reg - CW'(1);
    assign num_bad = (num_reg == '0) || (num_reg > lim);
    assign num_set = rword[num_m1[WW-1:0]];

    always_comb
    begin
        priority if (cmd.load)
        begin
            ptr_next = (req_op == bba_pkg::OP_FREE) ? req_m1[WW+AW-1:WW] : '0;
        end
        else if (cmd.step)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = rword;
        if (cmd.decide_alloc && stat.hit)
        begin
            we    = 1'b1;
            wdata = rword | (WB'(1) << first_idx);
        end
        else if (cmd.decide_free && !num_bad && num_set)
        begin
            we    = 1'b1;
            wdata = rword & ~(WB'(1) << num_m1[WW-1:0]);
        end
    end

    // The read address is the pointer's next value, so the word for the
    // current pointer is always in the read register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[ptr_reg] <= wdata;
        end
        rdata_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            rvld_reg        <= 1'b0;
            block_count_reg <= bba_pkg::BLOCK_COUNT_RESET;
            used_reg        <= '0;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[ptr_reg] <= 1'b1;
            end
            rvld_reg <= vld_reg[ptr_next];
            ptr_reg  <= ptr_next;
            if (block_count_we)
            begin
                block_count_reg <= block_count_wdata;
            end
            if (cmd.decide_alloc && stat.hit)
            begin
                used_reg <= used_reg + CW'(1);
            end
            else if (cmd.decide_free && !num_bad && num_set && (used_reg != '0))
            begin
                used_reg <= used_reg - CW'(1);
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= req_slot_number;
        end
        if (cmd.decide_alloc)
        begin
            res_status_reg  <= stat.hit ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
            res_granted_reg <= stat.hit ? (CW'({ptr_reg, first_idx}) + CW'(1)) : '0;
        end
        else if (cmd.decide_free)
        begin
            res_granted_reg <= '0;
            priority if (num_bad)
            begin
                res_status_reg <= bba_pkg::ST_RANGE;
            end
            else if (!num_set)
            begin
                res_status_reg <= bba_pkg::ST_ALREADY_FREE;
            end
            else
            begin
                res_status_reg <= bba_pkg::ST_OK;
            end
        end
        if (cmd.push)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_free_reg    <= (lim > used_reg) ? (lim - used_reg) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_granted    = out_granted_reg;
    assign out_free_slots = out_free_reg;

endmodule

`default_nettype wire

@@ hdl/block_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// First-fit bitmap allocator over 8192 slots held as 256 words of 32 bits.
// ----------------------------------------------------------------------------
//  Channel       Dir  Handshake           Payload
//  req           in   valid/ready         op, slot_number
//  rsp           out  valid/ready         status, granted_number, free_slots
//  block_count   in   write enable only   block_count_wdata
//
// An allocation scans the bitmap words in order from the first until one has a
// clear bit below the limit or the last word is reached (1 to 256 words); the
// scan reads one word per cycle from the bitmap memory's single read port.
// A free checks and settles the word that holds its slot. Reset clears the map
// through per-word valid bits, so the block is ready straight away. A stalled
// response holds in the output register while the next request is taken in.
`default_nettype none

module block_bitmap_allocator_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bba_req_if.sink                           req,
    bba_rsp_if.source                         rsp,
    input  wire logic                         block_count_we,
    input  wire logic [bba_pkg::COUNT_W-1:0]  block_count_wdata
);

    bba_pkg::bba_cmd_t  cmd;
    bba_pkg::bba_stat_t stat;

    bba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .stat      (stat),
        .cmd       (cmd),
        .req_ready (req.ready)
    );

    bba_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_op            (req.op),
        .req_slot_number   (req.slot_number),
        .block_count_we    (block_count_we),
        .block_count_wdata (block_count_wdata),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_status        (rsp.status),
        .out_granted       (rsp.granted_number),
        .out_free_slots    (rsp.free_slots)
    );

endmodule

`default_nettype wire

@@ hdl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [1:0]                   rsp_status,
    input wire logic [bba_pkg::COUNT_W-1:0]  rsp_granted,
    input wire logic [bba_pkg::COUNT_W-1:0]  rsp_free_slots
);

    // A response that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response withdrawn before transfer");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    // A slot number is granted only with an ok status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_granted != '0)) |-> (rsp_status == bba_pkg::ST_OK))
        else $error("slot granted with a failing status");

    // Neither the free count nor a granted number exceeds the map.
    a_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_free_slots <= bba_pkg::COUNT_W'(bba_pkg::MAP_BITS)) &&
                       (rsp_granted <= bba_pkg::COUNT_W'(bba_pkg::MAP_BITS))))
        else $error("count outside the map");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_granted    (rsp.granted_number),
    .rsp_free_slots (rsp.free_slots)
);

`default_nettype wire
